@@ rtl/assert_macros.svh @@
// assertion macros used by uv_sphere_vertex_generator
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define UVS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define UVS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/uvs_pkg.sv @@
// types, constants and the arctangent table of the uv sphere vertex generator
// no dependencies
`timescale 1ns / 1ps

package uvs_pkg;

    localparam int RING_W   = 9;
    localparam int RES_W    = 8;
    localparam int RAD_W    = 16;
    localparam int POS_W    = 17;
    localparam int NRM_W    = 16;
    localparam int VNUM_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int PHASE_W  = 32;
    localparam int DIV_W    = RING_W + 31;
    localparam int DIV_STEP = 2;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    localparam int CX_W = 34;
    localparam int CZ_W = 33;
    localparam int U_W  = 32;

    localparam logic [RES_W-1:0] RES_MIN = 8'd2;
    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [U_W-1:0]  ONE_Q30     = 32'sd1073741824;

    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef enum logic [1:0] {
        CLS_TOP  = 2'd0,
        CLS_BOT  = 2'd1,
        CLS_RING = 2'd2,
        CLS_BAD  = 2'd3
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [VNUM_W-1:0] vnum;
    } sideband_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667331;
            5:  v = 30'd21354465;
            6:  v = 30'd10679838;
            7:  v = 30'd5340245;
            8:  v = 30'd2670163;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            16: v = 30'd10430;
            17: v = 30'd5215;
            18: v = 30'd2608;
            19: v = 30'd1304;
            20: v = 30'd652;
            21: v = 30'd326;
            22: v = 30'd163;
            23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [U_W-1:0] clamp_unit(input logic signed [CX_W-1:0] v);
        logic signed [U_W-1:0] r;
        if (v > CX_W'(ONE_Q30))
            r = ONE_Q30;
        else if (v < -CX_W'(ONE_Q30))
            r = -ONE_Q30;
        else
            r = v[U_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/uvs_if.sv @@
// item channels and configuration write channel of the uv sphere vertex generator
// depends on uvs_pkg
`timescale 1ns / 1ps

interface uvs_in_if;
    logic                           valid;
    logic                           ready;
    logic [uvs_pkg::RING_W-1:0]     ring;
    logic [uvs_pkg::RING_W-1:0]     column;

    modport source (output valid, ring, column, input ready);
    modport sink (input valid, ring, column, output ready);
endinterface

interface uvs_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [uvs_pkg::POS_W-1:0]   pos_x;
    logic signed [uvs_pkg::POS_W-1:0]   pos_y;
    logic signed [uvs_pkg::POS_W-1:0]   pos_z;
    logic signed [uvs_pkg::NRM_W-1:0]   normal_x;
    logic signed [uvs_pkg::NRM_W-1:0]   normal_y;
    logic signed [uvs_pkg::NRM_W-1:0]   normal_z;
    logic [uvs_pkg::VNUM_W-1:0]         vertex_number;
    logic                               in_range;

    modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    vertex_number, in_range, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  vertex_number, in_range, output ready);
endinterface

interface uvs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [uvs_pkg::CFG_IDX_W-1:0]  index;
    logic [uvs_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/uv_sphere_vertex_generator.sv @@
// Returns position, unit normal and buffer number of one UV sphere vertex per item.
// One item is accepted every clock while the output is not stalled; an item passes the
// input register, the twenty-stage phase divider, the one-iteration-per-stage CORDIC
// with its quadrant fold register and four multiply/round stages. The whole pipeline
// advances together and holds while a finished result is not taken. Configuration
// writes are always ready.
// depends on uvs_pkg, uvs_if, uvs_phase_div, uvs_cordic, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uv_sphere_vertex_generator #(
    parameter int CORDIC_STAGES = 16,
    parameter int RES_MAX       = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    uvs_in_if.sink      vtx_in,
    uvs_out_if.source   vtx_out,
    uvs_cfg_if.sink     cfg
);

    localparam int RW     = uvs_pkg::RES_W;
    localparam int KW     = uvs_pkg::RING_W;
    localparam int VW     = uvs_pkg::VNUM_W;
    localparam int UW     = uvs_pkg::U_W;
    localparam int SB_LAT = uvs_pkg::DIV_STAGES + CORDIC_STAGES + 1;
    localparam int VTOP   = SB_LAT + 4;

    // configuration
    logic [RW-1:0]               resolution_reg;
    logic [uvs_pkg::RAD_W-1:0]   radius_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= 8'd16;
            radius_reg     <= 16'd256;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                uvs_pkg::REG_RESOLUTION: resolution_reg <= cfg.data[RW-1:0];
                uvs_pkg::REG_RADIUS:     radius_reg     <= cfg.data;
                default:                 ;
            endcase
        end
    end

    logic [RW-1:0] res;
    always_comb
    begin
        if (resolution_reg < uvs_pkg::RES_MIN)
            res = uvs_pkg::RES_MIN;
        else if (32'(resolution_reg) > RES_MAX)
            res = RW'(RES_MAX);
        else
            res = resolution_reg;
    end

    // pipeline control
    logic           en;
    logic [VTOP:0]  v_reg;

    assign en           = !v_reg[VTOP] || vtx_out.ready;
    assign vtx_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[VTOP-1:0], vtx_in.valid};
    end

    // classification and vertex number
    logic [KW-1:0]          cols;
    logic [KW-1:0]          mul_a;
    logic [KW-1:0]          col_term;
    logic [2*KW-1:0]        vsum;
    uvs_pkg::sideband_t     sb_in;

    assign cols = {res, 1'b0};
    assign vsum = (2*KW)'(mul_a) * (2*KW)'(cols) + (2*KW)'(col_term) + (2*KW)'(1);

    always_comb
    begin
        mul_a    = vtx_in.ring - KW'(1);
        col_term = vtx_in.column;
        if (vtx_in.ring == '0)
            sb_in.cls = uvs_pkg::CLS_TOP;
        else if ({1'b0, vtx_in.ring} == {2'b00, res} + 10'd1)
            sb_in.cls = uvs_pkg::CLS_BOT;
        else if (vtx_in.ring <= {1'b0, res} && vtx_in.column < cols)
            sb_in.cls = uvs_pkg::CLS_RING;
        else
            sb_in.cls = uvs_pkg::CLS_BAD;
        if (sb_in.cls == uvs_pkg::CLS_BOT)
        begin
            mul_a    = {1'b0, res};
            col_term = '0;
        end
        if (sb_in.cls == uvs_pkg::CLS_RING || sb_in.cls == uvs_pkg::CLS_BOT)
            sb_in.vnum = vsum[VW-1:0];
        else
            sb_in.vnum = '0;
    end

    logic [KW-1:0]          ring_reg;
    logic [KW-1:0]          col_reg;
    uvs_pkg::sideband_t     sb_reg [0:SB_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ring_reg  <= vtx_in.ring;
            col_reg   <= vtx_in.column;
            sb_reg[0] <= sb_in;
            for (int i = 1; i <= SB_LAT; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // angles and sine/cosine
    logic [uvs_pkg::PHASE_W-1:0] phase_t;
    logic [uvs_pkg::PHASE_W-1:0] phase_p;
    logic signed [UW-1:0]        cos_t;
    logic signed [UW-1:0]        sin_t;
    logic signed [UW-1:0]        cos_p;
    logic signed [UW-1:0]        sin_p;

    uvs_phase_div u_div_t (.clk(clk), .en(en), .res(res), .k(ring_reg), .phase(phase_t));
    uvs_phase_div u_div_p (.clk(clk), .en(en), .res(res), .k(col_reg), .phase(phase_p));

    uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_t (
        .clk(clk), .en(en), .phase(phase_t), .cos_out(cos_t), .sin_out(sin_t)
    );
    uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_p (
        .clk(clk), .en(en), .phase(phase_p), .cos_out(cos_p), .sin_out(sin_p)
    );

    // stage 1: azimuth products
    logic signed [2*UW-1:0] prod_x_reg;
    logic signed [2*UW-1:0] prod_z_reg;
    logic signed [UW-1:0]   uy1_reg;
    uvs_pkg::sideband_t     sb1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= sin_t * cos_p;
            prod_z_reg <= sin_t * sin_p;
            uy1_reg    <= cos_t;
            sb1_reg    <= sb_reg[SB_LAT];
        end
    end

    // stage 2: round to unit vector, poles and bad indices override
    logic signed [2*UW-1:0] rx;
    logic signed [2*UW-1:0] rz;
    logic signed [UW-1:0]   ux_c;
    logic signed [UW-1:0]   uz_c;

    assign rx = (prod_x_reg + 64'sd536870912) >>> 30;
    assign rz = (prod_z_reg + 64'sd536870912) >>> 30;
    assign ux_c = (rx > 64'(uvs_pkg::ONE_Q30)) ? uvs_pkg::ONE_Q30 :
                  (rx < -64'(uvs_pkg::ONE_Q30)) ? -uvs_pkg::ONE_Q30 : rx[UW-1:0];
    assign uz_c = (rz > 64'(uvs_pkg::ONE_Q30)) ? uvs_pkg::ONE_Q30 :
                  (rz < -64'(uvs_pkg::ONE_Q30)) ? -uvs_pkg::ONE_Q30 : rz[UW-1:0];

    logic signed [UW-1:0] ux2_reg;
    logic signed [UW-1:0] uy2_reg;
    logic signed [UW-1:0] uz2_reg;
    logic                 ok2_reg;
    logic [VW-1:0]        vnum2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vnum2_reg <= sb1_reg.vnum;
            ok2_reg   <= (sb1_reg.cls != uvs_pkg::CLS_BAD);
            case (sb1_reg.cls)
                uvs_pkg::CLS_RING:
                begin
                    ux2_reg <= ux_c;
                    uy2_reg <= uy1_reg;
                    uz2_reg <= uz_c;
                end
                uvs_pkg::CLS_TOP:
                begin
                    ux2_reg <= '0;
                    uy2_reg <= uvs_pkg::ONE_Q30;
                    uz2_reg <= '0;
                end
                uvs_pkg::CLS_BOT:
                begin
                    ux2_reg <= '0;
                    uy2_reg <= -uvs_pkg::ONE_Q30;
                    uz2_reg <= '0;
                end
                default:
                begin
                    ux2_reg <= '0;
                    uy2_reg <= '0;
                    uz2_reg <= '0;
                end
            endcase
        end
    end

    // stage 3: radius products and normals
    localparam int PW = uvs_pkg::RAD_W + 1 + UW;

    logic signed [uvs_pkg::RAD_W:0] rad_s;
    logic signed [UW-1:0]           nx_full;
    logic signed [UW-1:0]           ny_full;
    logic signed [UW-1:0]           nz_full;
    logic signed [PW-1:0]           px3_reg;
    logic signed [PW-1:0]           py3_reg;
    logic signed [PW-1:0]           pz3_reg;
    logic signed [uvs_pkg::NRM_W-1:0] nx3_reg;
    logic signed [uvs_pkg::NRM_W-1:0] ny3_reg;
    logic signed [uvs_pkg::NRM_W-1:0] nz3_reg;
    logic                           ok3_reg;
    logic [VW-1:0]                  vnum3_reg;

    assign rad_s   = $signed({1'b0, radius_reg});
    assign nx_full = (ux2_reg + 32'sd32768) >>> 16;
    assign ny_full = (uy2_reg + 32'sd32768) >>> 16;
    assign nz_full = (uz2_reg + 32'sd32768) >>> 16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px3_reg   <= rad_s * ux2_reg;
            py3_reg   <= rad_s * uy2_reg;
            pz3_reg   <= rad_s * uz2_reg;
            nx3_reg   <= nx_full[uvs_pkg::NRM_W-1:0];
            ny3_reg   <= ny_full[uvs_pkg::NRM_W-1:0];
            nz3_reg   <= nz_full[uvs_pkg::NRM_W-1:0];
            ok3_reg   <= ok2_reg;
            vnum3_reg <= vnum2_reg;
        end
    end

    // stage 4: output register
    logic signed [PW-1:0] px_r;
    logic signed [PW-1:0] py_r;
    logic signed [PW-1:0] pz_r;

    assign px_r = (px3_reg + PW'(536870912)) >>> 30;
    assign py_r = (py3_reg + PW'(536870912)) >>> 30;
    assign pz_r = (pz3_reg + PW'(536870912)) >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vtx_out.pos_x         <= px_r[uvs_pkg::POS_W-1:0];
            vtx_out.pos_y         <= py_r[uvs_pkg::POS_W-1:0];
            vtx_out.pos_z         <= pz_r[uvs_pkg::POS_W-1:0];
            vtx_out.normal_x      <= nx3_reg;
            vtx_out.normal_y      <= ny3_reg;
            vtx_out.normal_z      <= nz3_reg;
            vtx_out.vertex_number <= vnum3_reg;
            vtx_out.in_range      <= ok3_reg;
        end
    end

    assign vtx_out.valid = v_reg[VTOP];

    logic out_zero;
    logic ny_unit;

    assign out_zero = vtx_out.pos_x == 0 && vtx_out.pos_y == 0 && vtx_out.pos_z == 0 &&
                      vtx_out.normal_y == 0 && vtx_out.vertex_number == 0;
    assign ny_unit  = vtx_out.normal_y <= 16'sd16384 && vtx_out.normal_y >= -16'sd16384;

    // a rejected index leaves zeros in the position, normal_y and vertex number fields
    `UVS_ASSERT_IMP(a_reject_zero, vtx_out.valid && !vtx_out.in_range, out_zero)
    `UVS_ASSERT_IMP(a_normal_unit, vtx_out.valid && vtx_out.in_range, ny_unit)
    // a stalled pipeline neither drops nor invents items
    `UVS_ASSERT_NXT(a_stall_hold, !en, $stable(v_reg))

endmodule

@@ rtl/uvs_phase_div.sv @@
// pipelined restoring divider: phase = round(k * 2^31 / res), two quotient bits a stage
// depends on uvs_pkg
`timescale 1ns / 1ps

module uvs_phase_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic [uvs_pkg::RES_W-1:0]       res,
    input  logic [uvs_pkg::RING_W-1:0]      k,
    output logic [uvs_pkg::PHASE_W-1:0]     phase
);

    localparam int W  = uvs_pkg::DIV_W;
    localparam int RW = uvs_pkg::RES_W;
    localparam int NS = uvs_pkg::DIV_STAGES;

    logic [RW-1:0] rem_reg [0:NS-1];
    logic [W-1:0]  work_reg [0:NS-1];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [W-1:0]  work_in;
        logic [RW-1:0] rem_next;
        logic [W-1:0]  work_next;

        if (s == 0) begin : g_first
            // dividend carries the rounding half of the divisor
            assign rem_in  = '0;
            assign work_in = {k, 31'b0} + W'(res >> 1);
        end else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign work_in = work_reg[s-1];
        end

        always_comb
        begin
            logic [RW:0] trial;
            logic        qbit;
            rem_next  = rem_in;
            work_next = work_in;
            for (int b = 0; b < uvs_pkg::DIV_STEP; b++)
            begin
                trial = {rem_next, work_next[W-1]};
                if (trial >= {1'b0, res})
                begin
                    trial = trial - {1'b0, res};
                    qbit  = 1'b1;
                end
                else
                begin
                    qbit = 1'b0;
                end
                rem_next  = trial[RW-1:0];
                work_next = {work_next[W-2:0], qbit};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                work_reg[s] <= work_next;
            end
        end
    end

    assign phase = work_reg[NS-1][uvs_pkg::PHASE_W-1:0];

endmodule

@@ rtl/uvs_cordic.sv @@
// pipelined rotation-mode cordic, one iteration a stage, quadrant fold at the end
// depends on uvs_pkg
`timescale 1ns / 1ps

module uvs_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [uvs_pkg::PHASE_W-1:0]         phase,
    output logic signed [uvs_pkg::U_W-1:0]      cos_out,
    output logic signed [uvs_pkg::U_W-1:0]      sin_out
);

    localparam int XW = uvs_pkg::CX_W;
    localparam int ZW = uvs_pkg::CZ_W;

    logic signed [XW-1:0] x_reg [0:STAGES-1];
    logic signed [XW-1:0] y_reg [0:STAGES-1];
    logic signed [ZW-1:0] z_reg [0:STAGES-1];
    logic [1:0]           quad_reg [0:STAGES-1];

    for (genvar s = 0; s < STAGES; s++) begin : g_iter
        localparam logic [29:0] ATAN = uvs_pkg::atan_turn(s);
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic [1:0]           q_in;

        if (s == 0) begin : g_first
            assign x_in = uvs_pkg::CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = $signed({3'b000, phase[29:0]});
            assign q_in = phase[31:30];
        end else begin : g_rest
            assign x_in = x_reg[s-1];
            assign y_in = y_reg[s-1];
            assign z_in = z_reg[s-1];
            assign q_in = quad_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quad_reg[s] <= q_in;
                if (z_in >= 0)
                begin
                    x_reg[s] <= x_in - (y_in >>> s);
                    y_reg[s] <= y_in + (x_in >>> s);
                    z_reg[s] <= z_in - $signed({3'b000, ATAN});
                end
                else
                begin
                    x_reg[s] <= x_in + (y_in >>> s);
                    y_reg[s] <= y_in - (x_in >>> s);
                    z_reg[s] <= z_in + $signed({3'b000, ATAN});
                end
            end
        end
    end

    logic signed [uvs_pkg::U_W-1:0] xc;
    logic signed [uvs_pkg::U_W-1:0] yc;
    logic signed [uvs_pkg::U_W-1:0] cos_reg;
    logic signed [uvs_pkg::U_W-1:0] sin_reg;

    assign xc = uvs_pkg::clamp_unit(x_reg[STAGES-1]);
    assign yc = uvs_pkg::clamp_unit(y_reg[STAGES-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (quad_reg[STAGES-1])
                uvs_pkg::QUAD_0:
                begin
                    cos_reg <= xc;
                    sin_reg <= yc;
                end
                uvs_pkg::QUAD_1:
                begin
                    cos_reg <= -yc;
                    sin_reg <= xc;
                end
                uvs_pkg::QUAD_2:
                begin
                    cos_reg <= -xc;
                    sin_reg <= -yc;
                end
                default:
                begin
                    cos_reg <= yc;
                    sin_reg <= -xc;
                end
            endcase
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for uv_sphere_vertex_generator: vertex items against a predictor
// depends on uvs_pkg, uvs_if and the rtl of the generator
`timescale 1ns / 1ps

module testbench;

    localparam int N_STAGES    = 16;
    localparam int MAX_RES     = 255;
    localparam int PIPE_DEPTH  = N_STAGES + 27;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 220;

    typedef struct {
        logic [uvs_pkg::RING_W-1:0] ring;
        logic [uvs_pkg::RING_W-1:0] column;
    } grid_pos_t;

    typedef struct {
        logic signed [uvs_pkg::POS_W-1:0] px, py, pz;
        logic signed [uvs_pkg::NRM_W-1:0] nx, ny, nz;
        logic [uvs_pkg::VNUM_W-1:0]       vnum;
        logic                             ok;
    } vertex_t;

    logic clk;
    logic rst_n;
    uvs_in_if  vin();
    uvs_out_if vout();
    uvs_cfg_if cfgc();

    uv_sphere_vertex_generator dut (
        .clk(clk),
        .rst_n(rst_n),
        .vtx_in(vin),
        .vtx_out(vout),
        .cfg(cfgc)
    );

    grid_pos_t pending_items[$];
    vertex_t   expected_vertices[$];
    logic [uvs_pkg::RES_W-1:0] cur_res;
    logic [uvs_pkg::RAD_W-1:0] cur_radius;
    int  errors;
    int  cycles;
    int  send_idle;
    int  recv_idle;
    int  hold_left;
    logic in_took;

    longint atan_tab[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unit_clamp(input longint v);
        if (v > 64'sd1073741824)
            return 64'sd1073741824;
        if (v < -64'sd1073741824)
            return -64'sd1073741824;
        return v;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void turn_sin_cos(input logic [31:0] phase, output longint c,
                                         output longint s);
        longint x, y, z, dx, dy;
        x = uvs_pkg::CORDIC_GAIN;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < N_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
            else
            begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        x = unit_clamp(x);
        y = unit_clamp(y);
        case (phase[31:30])
            uvs_pkg::QUAD_0: begin c = x;  s = y;  end
            uvs_pkg::QUAD_1: begin c = -y; s = x;  end
            uvs_pkg::QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [31:0] angle_phase(input longint unsigned k,
                                                input longint unsigned res);
        longint unsigned q;
        q = ((k << 31) + res / 2) / res;
        return q[31:0];
    endfunction

    function automatic int eff_res(input logic [uvs_pkg::RES_W-1:0] r);
        if (r < 2)
            return 2;
        if (r > MAX_RES)
            return MAX_RES;
        return r;
    endfunction

    function automatic vertex_t predict_vertex(input grid_pos_t p);
        vertex_t v;
        longint ux, uy, uz, rad, ct, st, cp, sp;
        int res, cols;
        res = eff_res(cur_res);
        cols = 2 * res;
        rad = longint'(cur_radius);
        ux = 0; uy = 0; uz = 0;
        v = '{default: '0};
        v.ok = 1'b1;
        if (p.ring == 0)
        begin
            uy = 64'sd1073741824;
            v.vnum = '0;
        end
        else if (p.ring == res + 1)
        begin
            uy = -64'sd1073741824;
            v.vnum = uvs_pkg::VNUM_W'(cols * res + 1);
        end
        else if (p.ring <= res && p.column < cols)
        begin
            turn_sin_cos(angle_phase(p.ring, res), ct, st);
            turn_sin_cos(angle_phase(p.column, res), cp, sp);
            ux = unit_clamp(round_shift(st * cp, 30));
            uy = ct;
            uz = unit_clamp(round_shift(st * sp, 30));
            v.vnum = uvs_pkg::VNUM_W'(1 + (p.ring - 1) * cols + p.column);
        end
        else
            v.ok = 1'b0;
        if (v.ok)
        begin
            v.px = uvs_pkg::POS_W'(round_shift(rad * ux, 30));
            v.py = uvs_pkg::POS_W'(round_shift(rad * uy, 30));
            v.pz = uvs_pkg::POS_W'(round_shift(rad * uz, 30));
            v.nx = uvs_pkg::NRM_W'(round_shift(ux, 16));
            v.ny = uvs_pkg::NRM_W'(round_shift(uy, 16));
            v.nz = uvs_pkg::NRM_W'(round_shift(uz, 16));
        end
        else
            v.vnum = '0;
        return v;
    endfunction

    // input side: accept at the rising edge, predict with the settings in force
    always @(posedge clk)
    begin
        in_took <= 1'b0;
        if (rst_n && vin.valid && vin.ready)
        begin
            expected_vertices.push_back(predict_vertex(pending_items[0]));
            void'(pending_items.pop_front());
            in_took <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            vin.valid <= 1'b0;
        else if (vin.valid && !in_took)
            vin.valid <= 1'b1;
        else if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle)
        begin
            vin.valid  <= 1'b1;
            vin.ring   <= pending_items[0].ring;
            vin.column <= pending_items[0].column;
        end
        else
            vin.valid <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            vout.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            vout.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic report(input string fld, input longint exp_v, input longint act_v);
        $display("%0t mismatch %s expected %0d actual %0d", $time, fld, exp_v, act_v);
        errors++;
    endtask

    always @(posedge clk)
    begin
        vertex_t e;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
        if (rst_n && vout.valid && vout.ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                $display("%0t unexpected vertex item, vertex_number %0d", $time,
                         vout.vertex_number);
                errors++;
            end
            else
            begin
                e = expected_vertices.pop_front();
                if (vout.pos_x !== e.px) report("pos_x", e.px, vout.pos_x);
                if (vout.pos_y !== e.py) report("pos_y", e.py, vout.pos_y);
                if (vout.pos_z !== e.pz) report("pos_z", e.pz, vout.pos_z);
                if (vout.normal_x !== e.nx) report("normal_x", e.nx, vout.normal_x);
                if (vout.normal_y !== e.ny) report("normal_y", e.ny, vout.normal_y);
                if (vout.normal_z !== e.nz) report("normal_z", e.nz, vout.normal_z);
                if (vout.vertex_number !== e.vnum)
                    report("vertex_number", e.vnum, vout.vertex_number);
                if (vout.in_range !== e.ok) report("in_range", e.ok, vout.in_range);
            end
        end
    end

    task automatic write_reg(input logic [uvs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uvs_pkg::CFG_DAT_W-1:0] d);
        @(negedge clk);
        cfgc.valid <= 1'b1;
        cfgc.index <= idx;
        cfgc.data  <= d;
        do
            @(posedge clk);
        while (!cfgc.ready);
        if (idx == uvs_pkg::REG_RESOLUTION)
            cur_res = d[uvs_pkg::RES_W-1:0];
        else if (idx == uvs_pkg::REG_RADIUS)
            cur_radius = d;
        @(negedge clk);
        cfgc.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && expected_vertices.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    task automatic add_item(input int r, input int c);
        grid_pos_t p;
        p.ring = uvs_pkg::RING_W'(r);
        p.column = uvs_pkg::RING_W'(c);
        pending_items.push_back(p);
    endtask

    // mostly valid grid points, some just past the edges, some pure noise
    task automatic add_random_items(input int n);
        int res, sel;
        res = eff_res(cur_res);
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
                add_item($urandom_range(0, res + 1), $urandom_range(0, 2 * res - 1));
            else if (sel < 85)
                add_item(res + 1 + $urandom_range(1, 3), $urandom_range(0, 511));
            else if (sel < 90)
                add_item($urandom_range(1, res),
                         (2 * res + $urandom_range(0, 3)) & 9'h1FF);
            else
                add_item($urandom_range(0, 511), $urandom_range(0, 511));
        end
    endtask

    initial
    begin
        int rs[7];
        int rd[7];
        rs = '{0, 255, 2, 3, 255, 1, 16};
        rd = '{65535, 0, 1, 12345, 65535, 256, 200};
        rst_n = 1'b0;
        errors = 0;
        cycles = 0;
        hold_left = 0;
        in_took = 1'b0;
        send_idle = 19;
        recv_idle = 66;
        vin.valid = 1'b0;
        vin.ring = '0;
        vin.column = '0;
        vout.ready = 1'b0;
        cfgc.valid = 1'b0;
        cfgc.index = '0;
        cfgc.data = '0;
        cur_res = 8'd16;
        cur_radius = 16'd256;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // poles with odd columns, edges of rings and columns, out of range
        add_item(0, 0);     add_item(0, 511);   add_item(17, 5);   add_item(17, 511);
        add_item(18, 0);    add_item(511, 511); add_item(1, 0);    add_item(16, 31);
        add_item(16, 32);   add_item(8, 8);     add_item(4, 0);    add_item(1, 31);
        add_item(12, 20);   add_item(1, 511);   add_item(9, 16);   add_item(0, 256);
        add_item(256, 0);   add_item(2, 7);
        wait_idle();

        // unused register indexes must be ignored
        write_reg(2'd2, 16'($urandom));
        write_reg(2'd3, 16'($urandom));
        add_item(16, 31);
        add_item(17, 0);
        wait_idle();

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 2)
            begin
                send_idle = 66;
                recv_idle = 19;
            end
            else if (ph == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(uvs_pkg::REG_RESOLUTION,
                      (ph == 5) ? 16'($urandom_range(2, 255)) : 16'(rs[ph]));
            write_reg(uvs_pkg::REG_RADIUS, (ph == 5) ? 16'($urandom) : 16'(rd[ph]));
            if (ph == 4)
                hold_left = 400;
            add_random_items(PHASE_ITEMS);
            wait_idle();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
